>>> hw/rtl/twelve_bit_minicomputer_step_assert.svh
// Assertion helper macros
`ifndef TWELVE_BIT_MINICOMPUTER_STEP_ASSERT_SVH
`define TWELVE_BIT_MINICOMPUTER_STEP_ASSERT_SVH
`define TBM_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TBM_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

>>> hw/rtl/tbm_pkg.sv
package tbm_pkg;
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_SETPC = 2'd1;
    localparam logic [1:0] KIND_EXEC = 2'd2;

    localparam logic [2:0] ST_RUN = 3'd0;
    localparam logic [2:0] ST_HALT = 3'd1;
    localparam logic [2:0] ST_BAD_IOT = 3'd2;
    localparam logic [2:0] ST_BAD_G2 = 3'd3;
    localparam logic [2:0] ST_BAD_G1 = 3'd4;

    localparam logic [2:0] OP_AND = 3'd0;
    localparam logic [2:0] OP_TAD = 3'd1;
    localparam logic [2:0] OP_ISZ = 3'd2;
    localparam logic [2:0] OP_DCA = 3'd3;
    localparam logic [2:0] OP_JMS = 3'd4;
    localparam logic [2:0] OP_JMP = 3'd5;
    localparam logic [2:0] OP_IOT = 3'd6;
    localparam logic [2:0] OP_OPR = 3'd7;

    localparam logic [5:0] DEV_KBD = 6'd3;
    localparam logic [5:0] DEV_TTY = 6'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] load_address;
        logic [11:0] value;
        logic [7:0]  key_byte;
    } t_in;

    typedef struct packed {
        logic [11:0] pc_before;
        logic [11:0] instruction_word;
        logic [11:0] accumulator;
        logic        link;
        logic [2:0]  status;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic [31:0] cycle_count;
    } t_out;
endpackage

>>> hw/rtl/tbm_if.sv
interface tbm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/twelve_bit_minicomputer_step.sv
// Twelve-bit minicomputer core, one step per input beat.
// Input channel (tbm_if sink): kind, load_address, value, key_byte.
//   kind 0 writes a memory word, 1 sets the PC and clears the halt code,
//   2 executes the instruction at the PC unless a halt code is set.
// Output channel (tbm_if source): one result beat per input beat with the
//   PC before the step, fetched word, AC, link, status, printer byte and
//   the running memory-cycle count.
// Execute steps through a fetch read, an optional indirect pointer read
//   and an operand read with write-back, all on the single port pair of
//   the word memory; load and set-PC go straight to the output register.
// Loads go one per cycle unless the receiver stalls; no beat is taken
//   mid-instruction. After reset the core clears all MEM_WORDS words,
//   one word a cycle, before the first input beat is accepted.
// A result waits in the output register while the receiver stalls; a new
//   beat is taken only once the previous result has left or is leaving.
module twelve_bit_minicomputer_step #(
    parameter int MEM_WORDS = 4096
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tbm_if.sink   i_in,
    tbm_if.source o_out
);
    localparam int AW = $clog2(MEM_WORDS);

    localparam logic [2:0] S_CLR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_IND = 3'd3;
    localparam logic [2:0] S_OPND = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [11:0]   r_pc, n_pc;
    logic [11:0]   r_ac, n_ac;
    logic          r_l, n_l;
    logic [2:0]    r_halt, n_halt;
    logic [31:0]   r_cyc, n_cyc;
    logic [11:0]   r_ir, n_ir;
    logic [11:0]   r_ea, n_ea;
    logic [7:0]    r_key, n_key;
    logic          r_ov, n_ov;
    tbm_pkg::t_out r_out, n_out;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [11:0]   wdata, rdata;

    tbm_ram #(.WIDTH(12), .DEPTH(MEM_WORDS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic out_free;
    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign o_out.valid = r_ov;
    assign o_out.data = r_out;

    logic [11:0] ea0, iz, g1a;
    logic [12:0] t13;
    logic        any, skip, g1l;
    logic [5:0]  dev;

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_pc = r_pc; n_ac = r_ac; n_l = r_l;
        n_halt = r_halt; n_cyc = r_cyc; n_ir = r_ir; n_ea = r_ea; n_key = r_key;
        n_ov = r_ov && !o_out.ready; n_out = r_out;
        we = 1'b0; waddr = r_clr; wdata = '0; raddr = r_pc[AW-1:0];
        ea0 = {(rdata[7] ? r_pc[11:7] : 5'd0), rdata[6:0]};
        iz = rdata + 12'd1; t13 = '0; any = 1'b0; skip = 1'b0;
        g1a = r_ac; g1l = r_l; dev = r_ir[8:3];
        unique case (r_state)
            S_CLR: begin
                we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(MEM_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in.valid && out_free) begin
                    n_out = '0;
                    n_out.pc_before = r_pc;
                    n_key = i_in.data.key_byte;
                    case (i_in.data.kind)
                        tbm_pkg::KIND_LOAD: begin
                            we = 1'b1;
                            waddr = i_in.data.load_address[AW-1:0];
                            wdata = i_in.data.value;
                            n_ov = 1'b1;
                        end
                        tbm_pkg::KIND_SETPC: begin
                            n_pc = i_in.data.value;
                            n_halt = tbm_pkg::ST_RUN;
                            n_ov = 1'b1;
                        end
                        tbm_pkg::KIND_EXEC: begin
                            if (r_halt == tbm_pkg::ST_RUN) n_state = S_FETCH;
                            else n_ov = 1'b1;
                        end
                        default: n_ov = 1'b1;
                    endcase
                    n_out.accumulator = r_ac; n_out.link = r_l;
                    n_out.status = (i_in.data.kind == tbm_pkg::KIND_SETPC)
                                   ? tbm_pkg::ST_RUN : r_halt;
                    n_out.cycle_count = r_cyc;
                end
            end
            S_FETCH: begin
                n_ir = rdata;
                n_ea = ea0;
                n_out.instruction_word = rdata;
                raddr = ea0[AW-1:0];
                if (rdata[11:9] < tbm_pkg::OP_IOT && rdata[8]) begin
                    n_cyc = r_cyc + 32'd1;
                    n_state = S_IND;
                end else begin
                    n_state = S_OPND;
                end
            end
            S_IND: begin
                // rdata holds the indirect pointer
                n_ea = rdata;
                raddr = rdata[AW-1:0];
                n_state = S_OPND;
            end
            S_OPND: begin
                // rdata holds mem[ea] (read issued last cycle)
                n_state = S_IDLE;
                n_ov = 1'b1;
                unique case (r_ir[11:9])
                    tbm_pkg::OP_AND: begin
                        n_ac = r_ac & rdata; n_pc = r_pc + 12'd1;
                        n_cyc = r_cyc + 32'd2;
                    end
                    tbm_pkg::OP_TAD: begin
                        t13 = {1'b0, r_ac} + {1'b0, rdata};
                        n_ac = t13[11:0]; n_l = r_l ^ t13[12];
                        n_pc = r_pc + 12'd1; n_cyc = r_cyc + 32'd2;
                    end
                    tbm_pkg::OP_ISZ: begin
                        we = 1'b1; waddr = r_ea[AW-1:0]; wdata = iz;
                        n_pc = r_pc + ((iz == 12'd0) ? 12'd2 : 12'd1);
                        n_cyc = r_cyc + 32'd2;
                    end
                    tbm_pkg::OP_DCA: begin
                        we = 1'b1; waddr = r_ea[AW-1:0]; wdata = r_ac;
                        n_ac = '0; n_pc = r_pc + 12'd1; n_cyc = r_cyc + 32'd2;
                    end
                    tbm_pkg::OP_JMS: begin
                        we = 1'b1; waddr = r_ea[AW-1:0]; wdata = r_pc + 12'd1;
                        n_pc = r_ea + 12'd1; n_cyc = r_cyc + 32'd2;
                    end
                    tbm_pkg::OP_JMP: begin
                        n_pc = r_ea; n_cyc = r_cyc + 32'd1;
                    end
                    tbm_pkg::OP_IOT: begin
                        if (dev == tbm_pkg::DEV_KBD) begin
                            n_ac = {4'd0, r_key}; n_pc = r_pc + 12'd1;
                            n_cyc = r_cyc + 32'd1;
                        end else if (dev == tbm_pkg::DEV_TTY) begin
                            n_out.out_valid = 1'b1; n_out.out_byte = r_ac[7:0];
                            n_pc = r_pc + 12'd1; n_cyc = r_cyc + 32'd1;
                        end else begin
                            n_halt = tbm_pkg::ST_BAD_IOT;
                        end
                    end
                    default: begin
                        n_cyc = r_cyc + 32'd1;
                        if (r_ir[8]) begin
                            if (r_ir[0]) begin
                                n_halt = tbm_pkg::ST_BAD_G2;
                            end else begin
                                any = (r_ir[6] && r_ac[11]) ||
                                      (r_ir[5] && r_ac == 12'd0) ||
                                      (r_ir[4] && r_l);
                                skip = r_ir[3] ? !any : any;
                                if (r_ir[7]) n_ac = '0;
                                if (r_ir[1]) n_halt = tbm_pkg::ST_HALT;
                                else n_pc = r_pc + (skip ? 12'd2 : 12'd1);
                            end
                        end else if (r_ir[3] && r_ir[2]) begin
                            n_halt = tbm_pkg::ST_BAD_G1;
                        end else begin
                            if (r_ir[7]) g1a = '0;
                            if (r_ir[6]) g1l = 1'b0;
                            if (r_ir[5]) g1a = ~g1a;
                            if (r_ir[4]) g1l = ~g1l;
                            if (r_ir[0]) begin
                                t13 = {1'b0, g1a} + 13'd1;
                                g1a = t13[11:0]; g1l = g1l ^ t13[12];
                            end
                            if (r_ir[3]) begin
                                {g1a, g1l} = {g1l, g1a};
                                if (r_ir[1]) {g1a, g1l} = {g1l, g1a};
                            end
                            if (r_ir[2]) begin
                                {g1l, g1a} = {g1a, g1l};
                                if (r_ir[1]) {g1l, g1a} = {g1a, g1l};
                            end
                            n_ac = g1a; n_l = g1l; n_pc = r_pc + 12'd1;
                        end
                    end
                endcase
                n_out.accumulator = n_ac; n_out.link = n_l;
                n_out.status = n_halt; n_out.cycle_count = n_cyc;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_pc <= '0; r_ac <= '0; r_l <= 1'b0;
            r_halt <= tbm_pkg::ST_RUN; r_cyc <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_pc <= n_pc; r_ac <= n_ac;
            r_l <= n_l; r_halt <= n_halt; r_cyc <= n_cyc; r_ov <= n_ov;
        end
        r_ir <= n_ir; r_ea <= n_ea; r_key <= n_key; r_out <= n_out;
    end
endmodule

>>> hw/rtl/tbm_ram.sv
module tbm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/tbm_checker.sv
`include "twelve_bit_minicomputer_step_assert.svh"
module tbm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input tbm_pkg::t_out i_out_data
);
    `TBM_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
    `TBM_ASSERT_IMPL(a_no_take_on_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready |-> !i_in_ready)
    `TBM_ASSERT_IMPL(a_byte_zero, i_clk, i_rst_n, i_out_valid && !i_out_data.out_valid |-> i_out_data.out_byte == 8'd0)
    `TBM_ASSERT_IMPL(a_status_range, i_clk, i_rst_n, i_out_valid |-> i_out_data.status <= tbm_pkg::ST_BAD_G1)
    `TBM_ASSERT_NORST(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid)
endmodule

bind twelve_bit_minicomputer_step tbm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_data(o_out.data)
);

>>> tb/sv/tb_twelve_bit_minicomputer_step.sv
module tb_twelve_bit_minicomputer_step;
    localparam int MEMW = 4096;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    tbm_if #(.T(tbm_pkg::t_in))  in_ch ();
    tbm_if #(.T(tbm_pkg::t_out)) out_ch ();

    twelve_bit_minicomputer_step #(.MEM_WORDS(MEMW)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model state
    logic [11:0] mdl_mem [MEMW];
    logic [11:0] mdl_pc;
    logic [11:0] mdl_ac;
    logic        mdl_l;
    logic [2:0]  mdl_halt;
    logic [31:0] mdl_cyc;

    tbm_pkg::t_in  stim_q [$];
    tbm_pkg::t_out want_q [$];
    int   errors = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   acc_cnt = 0;
    bit   rx_hold = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h", what, got, exp);
        errors++;
    endtask

    function automatic void rot_r();
        logic lo;
        lo = mdl_ac[0];
        mdl_ac = {mdl_l, mdl_ac[11:1]};
        mdl_l = lo;
    endfunction

    function automatic void rot_l();
        logic hi;
        hi = mdl_ac[11];
        mdl_ac = {mdl_ac[10:0], mdl_l};
        mdl_l = hi;
    endfunction

    function automatic void run_instr(input logic [11:0] ir, input logic [7:0] key,
                                      output logic ov, output logic [7:0] ob);
        logic [2:0]  op;
        logic [11:0] ea;
        logic [11:0] t;
        logic [12:0] sum;
        logic        any;
        logic        skip;
        op = ir[11:9];
        ov = 1'b0;
        ob = 8'd0;
        ea = {5'd0, ir[6:0]};
        if (ir[7]) ea = {mdl_pc[11:7], ir[6:0]};
        if (op != tbm_pkg::OP_IOT && op != tbm_pkg::OP_OPR && ir[8]) begin
            mdl_cyc++;
            ea = mdl_mem[ea];
        end
        case (op)
            tbm_pkg::OP_AND: begin
                mdl_ac &= mdl_mem[ea]; mdl_pc++; mdl_cyc += 2;
            end
            tbm_pkg::OP_TAD: begin
                sum = {1'b0, mdl_ac} + {1'b0, mdl_mem[ea]};
                if (sum[12]) mdl_l = ~mdl_l;
                mdl_ac = sum[11:0]; mdl_pc++; mdl_cyc += 2;
            end
            tbm_pkg::OP_ISZ: begin
                t = mdl_mem[ea] + 12'd1;
                mdl_mem[ea] = t;
                mdl_pc += (t == 12'd0) ? 12'd2 : 12'd1; mdl_cyc += 2;
            end
            tbm_pkg::OP_DCA: begin
                mdl_mem[ea] = mdl_ac; mdl_ac = '0; mdl_pc++; mdl_cyc += 2;
            end
            tbm_pkg::OP_JMS: begin
                mdl_mem[ea] = mdl_pc + 12'd1; mdl_pc = ea + 12'd1; mdl_cyc += 2;
            end
            tbm_pkg::OP_JMP: begin
                mdl_pc = ea; mdl_cyc++;
            end
            tbm_pkg::OP_IOT: begin
                if (ir[8:3] == tbm_pkg::DEV_KBD) begin
                    mdl_ac = {4'd0, key}; mdl_pc++; mdl_cyc++;
                end else if (ir[8:3] == tbm_pkg::DEV_TTY) begin
                    ov = 1'b1; ob = mdl_ac[7:0]; mdl_pc++; mdl_cyc++;
                end else begin
                    mdl_halt = tbm_pkg::ST_BAD_IOT;
                end
            end
            default: begin
                if (ir[8]) begin
                    if (ir[0]) begin
                        mdl_halt = tbm_pkg::ST_BAD_G2; mdl_cyc++;
                    end else begin
                        any = (ir[6] && mdl_ac[11]) || (ir[5] && mdl_ac == 12'd0)
                              || (ir[4] && mdl_l);
                        skip = ir[3] ? !any : any;
                        if (ir[7]) mdl_ac = '0;
                        mdl_cyc++;
                        if (ir[1]) mdl_halt = tbm_pkg::ST_HALT;
                        else mdl_pc += skip ? 12'd2 : 12'd1;
                    end
                end else if (ir[3] && ir[2]) begin
                    mdl_halt = tbm_pkg::ST_BAD_G1; mdl_cyc++;
                end else begin
                    if (ir[7]) mdl_ac = '0;
                    if (ir[6]) mdl_l = 1'b0;
                    if (ir[5]) mdl_ac = ~mdl_ac;
                    if (ir[4]) mdl_l = ~mdl_l;
                    if (ir[0]) begin
                        sum = {1'b0, mdl_ac} + 13'd1;
                        if (sum[12]) mdl_l = ~mdl_l;
                        mdl_ac = sum[11:0];
                    end
                    if (ir[3]) begin rot_r(); if (ir[1]) rot_r(); end
                    if (ir[2]) begin rot_l(); if (ir[1]) rot_l(); end
                    mdl_cyc++; mdl_pc++;
                end
            end
        endcase
    endfunction

    function automatic tbm_pkg::t_out predict_step(input tbm_pkg::t_in it);
        tbm_pkg::t_out r;
        logic ov;
        logic [7:0] ob;
        r = '0;
        r.pc_before = mdl_pc;
        ov = 1'b0; ob = 8'd0;
        if (it.kind == tbm_pkg::KIND_LOAD) begin
            mdl_mem[it.load_address] = it.value;
        end else if (it.kind == tbm_pkg::KIND_SETPC) begin
            mdl_pc = it.value; mdl_halt = tbm_pkg::ST_RUN;
        end else if (it.kind == tbm_pkg::KIND_EXEC && mdl_halt == tbm_pkg::ST_RUN) begin
            r.instruction_word = mdl_mem[mdl_pc];
            run_instr(mdl_mem[mdl_pc], it.key_byte, ov, ob);
        end
        r.accumulator = mdl_ac;
        r.link = mdl_l;
        r.status = mdl_halt;
        r.out_valid = ov;
        r.out_byte = ob;
        r.cycle_count = mdl_cyc;
        return r;
    endfunction

    function automatic tbm_pkg::t_in mk(input logic [1:0] k, input logic [11:0] a,
                                        input logic [11:0] v, input logic [7:0] key);
        tbm_pkg::t_in it;
        it.kind = k; it.load_address = a; it.value = v; it.key_byte = key;
        return it;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [11:0] rand_instr();
        logic [11:0] w;
        w = 12'($urandom);
        case ($urandom_range(0, 9))
            0: w[11:9] = tbm_pkg::OP_IOT;
            1: begin
                w[11:9] = tbm_pkg::OP_IOT; w[8:3] = 6'($urandom_range(3, 4));
            end
            2, 3: begin
                w[11:8] = {tbm_pkg::OP_OPR, 1'b0}; if (w[3]) w[2] = 1'b0;
            end
            4: begin w[11:8] = {tbm_pkg::OP_OPR, 1'b1}; w[1:0] = 2'd0; end
            5: w[11:9] = tbm_pkg::OP_OPR;
            default: ;
        endcase
        return w;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) tx_gap <= rand_gap();
            if (in_ch.valid && tx_gap == 0 && stim_q.size() > 0) begin
                in_ch.data <= stim_q.pop_front();
            end else if (!in_ch.valid && tx_gap == 0 && stim_q.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data <= stim_q.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
                if (tx_gap > 0 && !in_ch.valid) tx_gap <= tx_gap - 1;
            end
        end
    end

    // prediction at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            want_q.push_back(predict_step(in_ch.data));
            acc_cnt <= acc_cnt + 1;
        end
    end

    // long receiver stall once traffic is flowing, sender keeps offering
    initial begin
        wait (acc_cnt >= 300);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        tbm_pkg::t_out w;
        tbm_pkg::t_out g;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                g = out_ch.data;
                if (want_q.size() == 0) begin
                    $display("unexpected result beat");
                    errors++;
                end else begin
                    w = want_q.pop_front();
                    if (g.pc_before !== w.pc_before)
                        report("pc_before", g.pc_before, w.pc_before);
                    if (g.instruction_word !== w.instruction_word)
                        report("instruction_word", g.instruction_word, w.instruction_word);
                    if (g.accumulator !== w.accumulator)
                        report("accumulator", g.accumulator, w.accumulator);
                    if (g.link !== w.link) report("link", g.link, w.link);
                    if (g.status !== w.status) report("status", g.status, w.status);
                    if (g.out_valid !== w.out_valid)
                        report("out_valid", g.out_valid, w.out_valid);
                    if (g.out_byte !== w.out_byte) report("out_byte", g.out_byte, w.out_byte);
                    if (g.cycle_count !== w.cycle_count)
                        report("cycle_count", g.cycle_count, w.cycle_count);
                end
            end
            if (rx_hold) begin
                out_ch.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                rx_gap <= rand_gap();
            end
        end
    end

    // watchdog
    int idle_cnt = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("FAIL twelve_bit_minicomputer_step");
            $finish;
        end
    end

    initial begin
        logic [11:0] prog_base;
        logic [11:0] a;
        int n;
        for (int i = 0; i < MEMW; i++) mdl_mem[i] = '0;
        mdl_pc = '0; mdl_ac = '0; mdl_l = 1'b0; mdl_halt = tbm_pkg::ST_RUN; mdl_cyc = '0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: memory ops on page zero / current page, indirect, IOT, operates
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'h000, {tbm_pkg::OP_TAD, 9'h010}, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'h010, 12'hFFF, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'h001, {tbm_pkg::OP_TAD, 9'h010}, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'h002, {tbm_pkg::OP_AND, 9'h110}, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'h003, {tbm_pkg::OP_ISZ, 9'h011}, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'h011, 12'hFFF, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'h005, {tbm_pkg::OP_DCA, 9'h090}, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'h006,
                            {tbm_pkg::OP_IOT, tbm_pkg::DEV_KBD, 3'd0}, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'h007,
                            {tbm_pkg::OP_IOT, tbm_pkg::DEV_TTY, 3'd0}, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'h008, 12'hE0E, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'h009, 12'hF02, 8'h00));
        for (int i = 0; i < 11; i++)
            stim_q.push_back(mk(tbm_pkg::KIND_EXEC, 12'hFFF, 12'h000, 8'hFF));
        stim_q.push_back(mk(tbm_pkg::KIND_SETPC, 12'h000, 12'hFFF, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_LOAD, 12'hFFF, {tbm_pkg::OP_JMS, 9'h1FF}, 8'h00));
        stim_q.push_back(mk(tbm_pkg::KIND_EXEC, 12'h000, 12'h000, 8'h00));

        // random: short programs with random content, mixed with noise beats
        n = 0;
        while (n < 600) begin
            if ($urandom_range(0, 9) < 8) begin
                prog_base = 12'($urandom);
                for (int j = 0; j < 6; j++) begin
                    stim_q.push_back(mk(tbm_pkg::KIND_LOAD, prog_base + 12'(j),
                                        rand_instr(), 8'($urandom)));
                    n++;
                end
                for (int j = 0; j < 4; j++) begin
                    a = (j < 2) ? 12'($urandom_range(0, 127))
                                : {prog_base[11:7], 7'($urandom)};
                    stim_q.push_back(mk(tbm_pkg::KIND_LOAD, a, 12'($urandom), 8'($urandom)));
                    n++;
                end
                stim_q.push_back(mk(tbm_pkg::KIND_SETPC, 12'($urandom), prog_base,
                                    8'($urandom)));
                for (int j = 0; j < 8; j++)
                    stim_q.push_back(mk(tbm_pkg::KIND_EXEC, 12'($urandom), 12'($urandom),
                                        8'($urandom)));
                n += 9;
            end else begin
                stim_q.push_back(mk(2'($urandom), 12'($urandom), 12'($urandom),
                                    8'($urandom)));
                n++;
            end
        end

        wait (stim_q.size() == 0 && !in_ch.valid);
        wait (want_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS twelve_bit_minicomputer_step");
        end else begin
            $display("FAIL twelve_bit_minicomputer_step");
        end
        $finish;
    end
endmodule
